// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define AM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sxf_pkg.sv =====
// Shared types and constants for the sprite XOR frame store.
`default_nettype none

package sxf_pkg;

	localparam int DISPLAY_WIDTH_DEF  = 64;
	localparam int DISPLAY_HEIGHT_DEF = 32;
	localparam int LANES      = 8;   // pixels in one sprite row
	localparam int GLYPH_PIX  = 4;   // pixels in one glyph row
	localparam int POS_W      = 8;
	localparam int ROW_DATA_W = 64;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_XOR   = 2'd1,
		REQ_GLYPH = 2'd2,
		REQ_READ  = 2'd3
	} req_type_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RMW  = 1'b1
	} sxf_state_t;

	typedef struct packed {
		logic wr_en;
		logic clr_all;
	} sxf_wr_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sxf_if.sv =====
// Request and response channel interfaces.
`default_nettype none

interface sxf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] row_bits;
	logic       first_row;

	modport source (output valid, req_type, pos_x, pos_y, row_bits, first_row,
		input ready);
	modport sink (input valid, req_type, pos_x, pos_y, row_bits, first_row,
		output ready);
endinterface

interface sxf_rsp_if;
	logic        valid;
	logic        ready;
	logic        collision;
	logic [63:0] row_data;

	modport source (output valid, collision, row_data, input ready);
	modport sink (input valid, collision, row_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sxf_lane.sv =====
// One pixel lane: places a single sprite pixel in the display row, with clipping.
`default_nettype none

module sxf_lane
	import sxf_pkg::*;
#(
	parameter int DISPLAY_WIDTH = DISPLAY_WIDTH_DEF,
	parameter int LANE_IDX      = 0
) (
	input  wire logic [POS_W-1:0]         pos_x,
	input  wire logic                     pix,
	output logic      [DISPLAY_WIDTH-1:0] mask
);

	localparam int CW = $clog2(DISPLAY_WIDTH);
	localparam logic [DISPLAY_WIDTH-1:0] ONE = DISPLAY_WIDTH'(1);

	logic [POS_W:0] col;
	logic [CW-1:0]  sel;
	logic           lit;

	always_comb begin
		col  = {1'b0, pos_x} + (POS_W+1)'(LANE_IDX);
		lit  = pix && (col < (POS_W+1)'(DISPLAY_WIDTH));
		// column c lives at bit W-1-c
		sel  = CW'(DISPLAY_WIDTH - 1) - col[CW-1:0];
		mask = lit ? (ONE << sel) : '0;
	end

endmodule

`default_nettype wire

// ===== hdl/sxf_merge.sv =====
// Combines the lane masks into one row mask and holds it for the update cycle.
`default_nettype none

module sxf_merge
	import sxf_pkg::*;
#(
	parameter int DISPLAY_WIDTH = DISPLAY_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     load,
	input  wire logic [DISPLAY_WIDTH-1:0] lane_mask [LANES],
	output logic      [DISPLAY_WIDTH-1:0] mask_s1
);

	logic [DISPLAY_WIDTH-1:0] mask_all;

	always_comb begin
		mask_all = '0;
		for (int i = 0; i < LANES; i++) begin
			mask_all = mask_all | lane_mask[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mask_s1 <= mask_all;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sxf_store.sv =====
// Frame row memory with per-row valid bits, so a screen clear resets every row at once.
`default_nettype none

module sxf_store
	import sxf_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF,
	localparam int AW = $clog2(DISPLAY_HEIGHT)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_idx,
	output logic      [DISPLAY_WIDTH-1:0] rd_row,
	input  wire sxf_wr_ctl_t              wr_ctl,
	input  wire logic [AW-1:0]            wr_idx,
	input  wire logic [DISPLAY_WIDTH-1:0] wr_row
);

`include "assert_macros.svh"

	logic [DISPLAY_WIDTH-1:0]  mem [DISPLAY_HEIGHT];
	logic [DISPLAY_HEIGHT-1:0] vld_q;
	logic [DISPLAY_WIDTH-1:0]  rd_data_q;
	logic                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_ctl.wr_en) begin
			mem[wr_idx] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_ctl.clr_all) begin
				vld_q <= '0;
			end else if (wr_ctl.wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
			end
		end
	end

	// a row never written since the last clear reads as dark
	assign rd_row = rd_vld_q ? rd_data_q : '0;

	`AM_ASSERT(a_clr_empties, clk, arst_n, wr_ctl.clr_all |=> (vld_q == '0), "clear left a row valid")
	`AM_ASSERT(a_wr_excl, clk, arst_n, !(wr_ctl.clr_all && wr_ctl.wr_en), "clear and row write together")

endmodule

`default_nettype wire

// ===== hdl/sprite_xor_framebuffer.sv =====
// Top level of the sprite XOR frame store: lanes, merge, row store and control.
//
//  channel  dir  payload                                      handshake
//  req      in   req_type, pos_x, pos_y, row_bits, first_row  valid/ready
//  rsp      out  collision, row_data                          valid/ready
//
// Each request has two steps: accept plus registered row read, then the
// read-modify-write of that row together with loading the response register.
// The registered row read ahead of the write sets this; one request is in flight at a time.
// A new request is taken while the previous response still waits in rsp.
// Screen clear resets the per-row valid bits at once; no clearing pass after reset.
// A stalled rsp holds the update cycle until the response register frees up.
`default_nettype none

module sprite_xor_framebuffer
	import sxf_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sxf_req_if.sink   req,
	sxf_rsp_if.source rsp
);

`include "assert_macros.svh"

	localparam int AW = $clog2(DISPLAY_HEIGHT);

	sxf_state_t state_q, state_nxt;

	logic                     in_acc;
	logic                     on_scr;
	logic [DISPLAY_WIDTH-1:0] lane_mask [LANES];
	logic [DISPLAY_WIDTH-1:0] mask_s1;
	logic [DISPLAY_WIDTH-1:0] rd_row;
	logic [DISPLAY_WIDTH-1:0] row_cur;
	logic [DISPLAY_WIDTH-1:0] row_new;

	req_type_t                req_s1;
	logic                     on_scr_s1;
	logic                     first_s1;
	logic [AW-1:0]            idx_s1;

	logic                     flag_q;
	logic                     flag_nxt;
	logic                     hit;
	logic                     done;

	logic                     out_vld_q;
	logic                     out_coll_q;
	logic [ROW_DATA_W-1:0]    out_data_q;

	sxf_wr_ctl_t              wr_ctl;

	assign in_acc = req.valid && req.ready;
	assign on_scr = req.pos_y < POS_W'(DISPLAY_HEIGHT);

	// one lane per sprite pixel; glyph rows use only the first four lanes
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic pix;
		assign pix = req.row_bits[LANES-1-j]
			&& ((req.req_type != REQ_GLYPH) || (j < GLYPH_PIX));
		sxf_lane #(
			.DISPLAY_WIDTH(DISPLAY_WIDTH),
			.LANE_IDX     (j)
		) u_lane (
			.pos_x(req.pos_x),
			.pix  (pix),
			.mask (lane_mask[j])
		);
	end

	sxf_merge #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH)
	) u_merge (
		.clk      (clk),
		.load     (in_acc),
		.lane_mask(lane_mask),
		.mask_s1  (mask_s1)
	);

	sxf_store #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_en (in_acc && on_scr),
		.rd_idx(req.pos_y[AW-1:0]),
		.rd_row(rd_row),
		.wr_ctl(wr_ctl),
		.wr_idx(idx_s1),
		.wr_row(row_new)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1    <= req_type_t'(req.req_type);
			on_scr_s1 <= on_scr;
			first_s1  <= req.first_row;
			idx_s1    <= req.pos_y[AW-1:0];
		end
	end

	always_comb begin
		row_cur = on_scr_s1 ? rd_row : '0;
		hit     = |(row_cur & mask_s1);
		row_new = (req_s1 == REQ_XOR) ? (row_cur ^ mask_s1) : (row_cur | mask_s1);

		flag_nxt = flag_q;
		if (req_s1 == REQ_XOR) begin
			if (first_s1) begin
				flag_nxt = 1'b0;
			end
			if (on_scr_s1 && hit) begin
				flag_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt      = state_q;
		req.ready      = 1'b0;
		done           = 1'b0;
		wr_ctl.wr_en   = 1'b0;
		wr_ctl.clr_all = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_nxt = ST_RMW;
				end
			end
			ST_RMW: begin
				if (!out_vld_q || rsp.ready) begin
					done           = 1'b1;
					state_nxt      = ST_IDLE;
					wr_ctl.clr_all = (req_s1 == REQ_CLEAR);
					wr_ctl.wr_en   = on_scr_s1
						&& ((req_s1 == REQ_XOR) || (req_s1 == REQ_GLYPH));
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (done) begin
				flag_q    <= flag_nxt;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_coll_q <= flag_nxt;
			out_data_q <= (req_s1 == REQ_READ)
				? (ROW_DATA_W'(row_cur) << (ROW_DATA_W - DISPLAY_WIDTH)) : '0;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.collision = out_coll_q;
	assign rsp.row_data  = out_data_q;

	`AM_ASSERT(a_acc_to_rmw, clk, arst_n, in_acc |=> (state_q == ST_RMW), "accepted request did not reach update")
	`AM_ASSERT(a_done_to_rsp, clk, arst_n, done |=> rsp.valid, "finished request produced no response")
	`AM_ASSERT(a_flag_by_xor, clk, arst_n, $rose(flag_q) |-> $past(done && (req_s1 == REQ_XOR)), "collision set outside a sprite row")
	`AM_ASSERT(a_wr_in_rmw, clk, arst_n, (wr_ctl.wr_en || wr_ctl.clr_all) |-> done, "row store written outside update")

endmodule

`default_nettype wire

// ===== tb/sprite_xor_framebuffer_tb.sv =====
// Self-checking testbench for the sprite XOR frame store: directed edge cases and random draws.
`timescale 1ns / 100ps

module sprite_xor_framebuffer_tb;
	import sxf_pkg::*;

	localparam int SCREEN_W    = DISPLAY_WIDTH_DEF;
	localparam int SCREEN_H    = DISPLAY_HEIGHT_DEF;
	localparam int IDLE_PCT    = 18;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		req_type_t  kind;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] bits;
		logic       first;
	} draw_req_t;

	typedef struct {
		bit        collision;
		bit [63:0] row_data;
	} draw_rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sxf_req_if req_ch ();
	sxf_rsp_if rsp_ch ();

	sprite_xor_framebuffer #(
		.DISPLAY_WIDTH (SCREEN_W),
		.DISPLAY_HEIGHT(SCREEN_H)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the frame store
	bit [63:0] shadow_rows [SCREEN_H];
	bit        shadow_collision;

	draw_rsp_t pending_rsp [$];
	int        accepted_reqs = 0;
	int        mismatches    = 0;
	int        cycle_count   = 0;
	int        rsp_hold_left = 0;
	bit        no_idle       = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic bit idle_roll();
		return !no_idle && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// Pixels lit by an npix-wide row at column x, msb leftmost; columns off the right edge drop
	function automatic bit [63:0] lit_mask(bit [7:0] x, bit [7:0] bits, int npix);
		bit [63:0] m;
		int        col;
		m = '0;
		for (int j = 0; j < npix; j++) begin
			col = int'(x) + j;
			if (bits[npix - 1 - j] && col < SCREEN_W)
				m[63 - col] = 1'b1;
		end
		return m;
	endfunction

	function automatic draw_rsp_t predict_response(draw_req_t r);
		draw_rsp_t e;
		bit [63:0] m;
		bit        visible;
		visible    = r.y < SCREEN_H;
		e.row_data = '0;
		case (r.kind)
			REQ_CLEAR: begin
				for (int i = 0; i < SCREEN_H; i++)
					shadow_rows[i] = '0;
			end
			REQ_XOR: begin
				m = lit_mask(r.x, r.bits, LANES);
				if (r.first)
					shadow_collision = 1'b0;
				if (visible) begin
					if ((shadow_rows[r.y] & m) != '0)
						shadow_collision = 1'b1;
					shadow_rows[r.y] ^= m;
				end
			end
			REQ_GLYPH: begin
				m = lit_mask(r.x, r.bits >> 4, GLYPH_PIX);
				if (visible)
					shadow_rows[r.y] |= m;
			end
			default: begin
				if (visible)
					e.row_data = shadow_rows[r.y];
			end
		endcase
		e.collision = shadow_collision;
		return e;
	endfunction

	task automatic send_req(req_type_t kind, logic [7:0] x, logic [7:0] y, logic [7:0] bits,
		logic first);
		draw_req_t r;
		r = '{kind: kind, x: x, y: y, bits: bits, first: first};
		@(negedge clk);
		while (idle_roll()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.pos_x     <= x;
		req_ch.pos_y     <= y;
		req_ch.row_bits  <= bits;
		req_ch.first_row <= first;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		pending_rsp.push_back(predict_response(r));
		accepted_reqs++;
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp_ch.ready <= !idle_roll();
			end
		end
	end

	always @(posedge clk) begin
		draw_rsp_t e;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: response with nothing outstanding: collision=%0b row_data=%h",
						$time, rsp_ch.collision, rsp_ch.row_data);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_ch.collision !== e.collision || rsp_ch.row_data !== e.row_data) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: mismatch: collision exp %0b got %0b, row_data exp %h got %h",
							$time, e.collision, rsp_ch.collision, e.row_data, rsp_ch.row_data);
				end
			end
		end
	end

	task automatic test_directed_edges();
		send_req(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b0);  // frame empty after reset
		send_req(REQ_XOR,   8'd0,   8'd0,   8'hFF, 1'b1);
		send_req(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b0);
		send_req(REQ_XOR,   8'd0,   8'd0,   8'hFF, 1'b0);  // erases lit pixels: collision
		send_req(REQ_GLYPH, 8'd0,   8'd0,   8'hFF, 1'b1);  // first_row ignored, low nibble too
		send_req(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b1);
		send_req(REQ_CLEAR, 8'd0,   8'd0,   8'h00, 1'b1);  // flag survives a clear
		send_req(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b0);
		send_req(REQ_XOR,   8'd60,  8'd31,  8'hFF, 1'b1);  // right edge clip
		send_req(REQ_READ,  8'd0,   8'd31,  8'h00, 1'b0);
		send_req(REQ_XOR,   8'd63,  8'd31,  8'h80, 1'b0);
		send_req(REQ_XOR,   8'd255, 8'd31,  8'hFF, 1'b1);  // wholly off the right edge
		send_req(REQ_XOR,   8'd57,  8'd5,   8'hA5, 1'b0);
		send_req(REQ_XOR,   8'd10,  8'd32,  8'hFF, 1'b1);  // off the bottom, still clears flag
		send_req(REQ_XOR,   8'd0,   8'd255, 8'hFF, 1'b0);
		send_req(REQ_READ,  8'd0,   8'd32,  8'h00, 1'b0);
		send_req(REQ_READ,  8'd255, 8'd255, 8'hFF, 1'b1);
		send_req(REQ_GLYPH, 8'd62,  8'd31,  8'h3F, 1'b0);
		send_req(REQ_GLYPH, 8'd61,  8'd31,  8'hF0, 1'b0);
		send_req(REQ_READ,  8'd0,   8'd31,  8'h00, 1'b0);
		send_req(REQ_GLYPH, 8'd56,  8'd5,   8'hFF, 1'b0);  // OR over lit pixels, no collision
		send_req(REQ_READ,  8'd0,   8'd5,   8'h00, 1'b0);
		send_req(REQ_XOR,   8'd0,   8'd5,   8'h00, 1'b0);
		send_req(REQ_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0);
		send_req(REQ_READ,  8'd0,   8'd31,  8'h00, 1'b0);
	endtask

	// Mostly well-formed sprites and glyphs with random content, some read sweeps and noise
	task automatic random_traffic(int n_items);
		int         start;
		int         pick;
		int         rows;
		logic [7:0] x;
		logic [7:0] y;
		start = accepted_reqs;
		while (accepted_reqs - start < n_items) begin
			pick = $urandom_range(99);
			x = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(SCREEN_W - 1));
			y = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(SCREEN_H - 1));
			if (pick < 55) begin
				rows = $urandom_range(1, 15);
				for (int k = 0; k < rows; k++)
					send_req(REQ_XOR, x, y + 8'(k), 8'($urandom),
						k == 0 && $urandom_range(7) != 0);
			end else if (pick < 68) begin
				for (int k = 0; k < 5; k++)
					send_req(REQ_GLYPH, x, y + 8'(k), 8'($urandom), 1'($urandom));
			end else if (pick < 88) begin
				send_req(REQ_READ, x, y, 8'($urandom), 1'($urandom));
			end else if (pick < 90) begin
				for (int r = 0; r < SCREEN_H; r++)
					send_req(REQ_READ, 8'($urandom), 8'(r), 8'($urandom), 1'($urandom));
			end else begin
				send_req(req_type_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic test_random_sprites();
		random_traffic(1150);
	endtask

	task automatic test_full_rate();
		no_idle = 1'b1;
		random_traffic(350);
		no_idle = 1'b0;
	endtask

	// Receiver holds off while requests keep coming, so the block backs up
	task automatic test_output_backpressure();
		@(posedge clk);
		rsp_hold_left = 150;
		random_traffic(100);
	endtask

	initial begin
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_CLEAR;
		req_ch.pos_x     = '0;
		req_ch.pos_y     = '0;
		req_ch.row_bits  = '0;
		req_ch.first_row = 1'b0;
		for (int i = 0; i < SCREEN_H; i++)
			shadow_rows[i] = '0;
		shadow_collision = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_random_sprites();
		test_output_backpressure();
		test_full_rate();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sprite_xor_framebuffer.f =====
+incdir+hdl
hdl/sxf_pkg.sv
hdl/sxf_if.sv
hdl/sxf_lane.sv
hdl/sxf_merge.sv
hdl/sxf_store.sv
hdl/sprite_xor_framebuffer.sv
tb/sprite_xor_framebuffer_tb.sv
